FILE: design/lsmf_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// lsmf_pkg
// Types, constants and helper functions shared by the lamp state message
// filter: the ON/OFF matcher, field numbers, result codes and decimal steps.
// ---------------------------------------------------------------------------
package lsmf_pkg;

    // Default build settings
    localparam int unsigned PAYLOAD_LIMIT_DEF = 64;
    localparam int unsigned ORIGIN_BYTES_DEF  = 8;
    localparam int unsigned WIRE_VERSION_DEF  = 1;

    // Characters
    localparam logic [7:0] CH_PIPE = 8'h7C;
    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_O    = 8'h4F;
    localparam logic [7:0] CH_N    = 8'h4E;
    localparam logic [7:0] CH_F    = 8'h46;
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_9    = 8'h39;

    // Record field numbers (counted from one, saturating at seven)
    localparam logic [2:0] FLD_VERSION = 3'd1;
    localparam logic [2:0] FLD_STATE   = 3'd2;
    localparam logic [2:0] FLD_ORIGIN  = 3'd3;
    localparam logic [2:0] FLD_SEQ     = 3'd4;
    localparam logic [2:0] FLD_TS      = 3'd5;
    localparam logic [2:0] FLD_MAX     = 3'd7;

    localparam logic [6:0] COUNT_MAX = 7'd127;

    typedef enum logic [2:0] {
        M_START = 3'd0,
        M_O     = 3'd1,
        M_ON    = 3'd2,
        M_OF    = 3'd3,
        M_OFF   = 3'd4,
        M_FAIL  = 3'd5
    } t_match;

    typedef enum logic [1:0] {
        ACT_IGNORE = 2'd0,
        ACT_SET    = 2'd1,
        ACT_STALE  = 2'd2
    } t_action;

    // Register byte addresses
    localparam logic [3:0] ADDR_SELF_ID = 4'h0;
    localparam logic [3:0] ADDR_WINDOW  = 4'h8;
    localparam logic [31:0] WINDOW_RESET = 32'd3600;

    function automatic t_match match_step(input t_match m, input logic [7:0] c);
        t_match r;
        r = M_FAIL;
        if (m == M_START && c == CH_O) r = M_O;
        if (m == M_O && c == CH_N) r = M_ON;
        if (m == M_O && c == CH_F) r = M_OF;
        if (m == M_OF && c == CH_F) r = M_OFF;
        return r;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    // acc * 10 + digit, saturating at all ones
    function automatic logic [31:0] dec_u32(input logic [31:0] acc, input logic [7:0] c);
        logic [35:0] wide;
        logic [7:0]  dig;
        dig  = c - CH_0;
        wide = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {32'b0, dig[3:0]};
        return (wide[35:32] != 4'b0) ? 32'hFFFF_FFFF : wide[31:0];
    endfunction

    function automatic logic [7:0] dec_u8(input logic [7:0] acc, input logic [7:0] c);
        logic [11:0] wide;
        logic [7:0]  dig;
        dig  = c - CH_0;
        wide = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {8'b0, dig[3:0]};
        return (wide[11:8] != 4'b0) ? 8'hFF : wide[7:0];
    endfunction

endpackage
`default_nettype wire

FILE: design/lamp_state_message_filter_top.sv
`default_nettype none
// ---------------------------------------------------------------------------
// lamp_state_message_filter_top
// Lamp state message filter: per-byte parse of a legacy ON/OFF or a
// pipe-separated record, then echo, replay, tie and stale-ON judgement.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall) carries one payload byte per item with
//   i_last flagging the final byte; i_last_seq, i_current_on and i_now_epoch
//   are only looked at on that final byte.
//   Output channel (o_valid / i_stall) gives one result item per message,
//   none for the other bytes.
//   Three register stages: input register, parse stage (message state and
//   decoded record), judge stage into the output register. A result moves
//   through them in order. One byte per cycle while the receiver does not
//   stall; the parse stage updates the message state once per byte with a
//   single match step and one decimal accumulate.
//   When the receiver stalls a waiting result, the whole pipe holds and
//   o_stall rises in the same cycle; nothing is dropped.
//   Reset (synchronous, active low) empties the pipe, clears the message
//   state and sets self_id to 0 and stale_window to 3600. Registers sit on
//   an APB-style port: self_id at 0x0, stale_window at 0x8.
// ---------------------------------------------------------------------------
module lamp_state_message_filter_top #(
    parameter int unsigned PAYLOAD_LIMIT = lsmf_pkg::PAYLOAD_LIMIT_DEF,
    parameter int unsigned ORIGIN_BYTES  = lsmf_pkg::ORIGIN_BYTES_DEF,
    parameter int unsigned WIRE_VERSION  = lsmf_pkg::WIRE_VERSION_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready,
    // input items
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_last,
    input  wire logic [31:0] i_last_seq,
    input  wire logic        i_current_on,
    input  wire logic [31:0] i_now_epoch,
    // result items
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_action,
    output logic             o_msg_valid,
    output logic             o_lamp_on,
    output logic [7:0]       o_version,
    output logic [31:0]      o_sequence_res,
    output logic [31:0]      o_timestamp,
    output logic [63:0]      o_origin_id
);
    import lsmf_pkg::*;

    localparam logic [6:0] BYTE_LIMIT = 7'(PAYLOAD_LIMIT - 1);
    localparam logic [3:0] ORIGIN_CAP = 4'(ORIGIN_BYTES);
    localparam logic [7:0] VER_CODE   = 8'(WIRE_VERSION);

    // ---------------- configuration ----------------
    logic [63:0] r_self_id, r_self_me, n_self_me;
    logic [31:0] r_window;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    // id ends at its first zero byte
    always_comb begin
        logic alive;
        alive     = 1'b1;
        n_self_me = '0;
        for (int i = 7; i >= 0; i--) begin
            if (pwdata[i*8 +: 8] == 8'h00) alive = 1'b0;
            if (alive) n_self_me[i*8 +: 8] = pwdata[i*8 +: 8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_self_id <= '0;
            r_self_me <= '0;
            r_window  <= WINDOW_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[3])
                ADDR_SELF_ID[3]: begin
                    r_self_id <= pwdata;
                    r_self_me <= n_self_me;
                end
                default: r_window <= pwdata[31:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3])
            ADDR_SELF_ID[3]: prdata = r_self_id;
            default:         prdata = {32'b0, r_window};
        endcase
    end

    // ---------------- pipe control ----------------
    logic en;
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    // ---------------- input register ----------------
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;
    logic [31:0] r_in_last_seq, r_in_now;
    logic        r_in_cur_on;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (en) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in_byte     <= i_data_byte;
            r_in_last     <= i_last;
            r_in_last_seq <= i_last_seq;
            r_in_cur_on   <= i_current_on;
            r_in_now      <= i_now_epoch;
        end
    end

    // ---------------- parse stage ----------------
    logic [6:0]  r_byte_count, n_byte_count;
    logic [2:0]  r_field_index, n_field_index, fi_eff;
    logic        r_in_field, n_in_field;
    logic        r_nul_seen, n_nul_seen;
    logic        r_digit_stop, n_digit_stop, ds_eff;
    t_match      r_whole, n_whole, r_state_m, n_state_m;
    logic [7:0]  r_version_acc, n_version_acc;
    logic [63:0] r_origin_acc, n_origin_acc;
    logic [3:0]  r_origin_len, n_origin_len;
    logic [31:0] r_seq_acc, n_seq_acc, r_ts_acc, n_ts_acc;
    logic        c_digit;

    always_comb begin
        n_byte_count  = r_byte_count;
        n_field_index = r_field_index;
        n_in_field    = r_in_field;
        n_nul_seen    = r_nul_seen;
        n_digit_stop  = r_digit_stop;
        n_whole       = r_whole;
        n_state_m     = r_state_m;
        n_version_acc = r_version_acc;
        n_origin_acc  = r_origin_acc;
        n_origin_len  = r_origin_len;
        n_seq_acc     = r_seq_acc;
        n_ts_acc      = r_ts_acc;
        c_digit       = is_digit(r_in_byte);

        // opening byte of a token bumps the field number
        fi_eff = r_field_index;
        ds_eff = r_digit_stop;
        if (!r_in_field) begin
            if (r_field_index < FLD_MAX) fi_eff = r_field_index + 3'd1;
            ds_eff = 1'b0;
        end

        if (r_nul_seen || r_in_byte == CH_NUL) begin
            n_nul_seen = 1'b1;
        end else begin
            n_whole = match_step(r_whole, r_in_byte);
            if (r_in_byte == CH_PIPE) begin
                n_in_field = 1'b0;
            end else begin
                n_in_field    = 1'b1;
                n_field_index = fi_eff;
                n_digit_stop  = ds_eff;
                case (fi_eff)
                    FLD_VERSION: begin
                        if (!ds_eff) begin
                            if (c_digit) n_version_acc = dec_u8(r_version_acc, r_in_byte);
                            else         n_digit_stop  = 1'b1;
                        end
                    end
                    FLD_STATE: n_state_m = match_step(r_state_m, r_in_byte);
                    FLD_ORIGIN: begin
                        if (r_origin_len < ORIGIN_CAP) begin
                            for (int k = 0; k < 8; k++) begin
                                if (r_origin_len == 4'(k))
                                    n_origin_acc[(7-k)*8 +: 8] = r_in_byte;
                            end
                            n_origin_len = r_origin_len + 4'd1;
                        end
                    end
                    FLD_SEQ: begin
                        if (!ds_eff) begin
                            if (c_digit) n_seq_acc    = dec_u32(r_seq_acc, r_in_byte);
                            else         n_digit_stop = 1'b1;
                        end
                    end
                    FLD_TS: begin
                        if (!ds_eff) begin
                            if (c_digit) n_ts_acc     = dec_u32(r_ts_acc, r_in_byte);
                            else         n_digit_stop = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
        end

        if (r_byte_count < COUNT_MAX) n_byte_count = r_byte_count + 7'd1;
    end

    // decode on the final byte
    logic d_len_ok, d_whole_ok, d_rec_ok, d_valid, d_on;
    assign d_len_ok   = r_byte_count < BYTE_LIMIT;
    assign d_whole_ok = (n_whole == M_ON) || (n_whole == M_OFF);
    assign d_rec_ok   = (n_field_index >= FLD_TS) && (n_version_acc == VER_CODE)
                        && ((n_state_m == M_ON) || (n_state_m == M_OFF));
    assign d_valid    = d_len_ok && (d_whole_ok || d_rec_ok);
    assign d_on       = d_len_ok && (d_whole_ok ? (n_whole == M_ON)
                                                : (d_rec_ok && n_state_m == M_ON));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (en && r_in_valid && r_in_last)) begin
            r_byte_count  <= '0;
            r_field_index <= '0;
            r_in_field    <= 1'b0;
            r_nul_seen    <= 1'b0;
            r_digit_stop  <= 1'b0;
            r_whole       <= M_START;
            r_state_m     <= M_START;
            r_version_acc <= '0;
            r_origin_acc  <= '0;
            r_origin_len  <= '0;
            r_seq_acc     <= '0;
            r_ts_acc      <= '0;
        end else if (en && r_in_valid) begin
            r_byte_count  <= n_byte_count;
            r_field_index <= n_field_index;
            r_in_field    <= n_in_field;
            r_nul_seen    <= n_nul_seen;
            r_digit_stop  <= n_digit_stop;
            r_whole       <= n_whole;
            r_state_m     <= n_state_m;
            r_version_acc <= n_version_acc;
            r_origin_acc  <= n_origin_acc;
            r_origin_len  <= n_origin_len;
            r_seq_acc     <= n_seq_acc;
            r_ts_acc      <= n_ts_acc;
        end
    end

    // decoded record register
    logic        r_dec_valid;
    logic        r_dec_ok, r_dec_on, r_dec_cur_on;
    logic [7:0]  r_dec_ver;
    logic [31:0] r_dec_seq, r_dec_ts, r_dec_last_seq, r_dec_now;
    logic [63:0] r_dec_origin;
    logic        rec_take;
    assign rec_take = d_len_ok && !d_whole_ok && d_rec_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dec_valid <= 1'b0;
        end else if (en) begin
            r_dec_valid <= r_in_valid && r_in_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dec_ok       <= d_valid;
            r_dec_on       <= d_on;
            r_dec_ver      <= rec_take ? n_version_acc : 8'd0;
            r_dec_seq      <= rec_take ? n_seq_acc : 32'd0;
            r_dec_ts       <= rec_take ? n_ts_acc : 32'd0;
            r_dec_origin   <= rec_take ? n_origin_acc : 64'd0;
            r_dec_last_seq <= r_in_last_seq;
            r_dec_cur_on   <= r_in_cur_on;
            r_dec_now      <= r_in_now;
        end
    end

    // ---------------- judge stage ----------------
    t_action     j_action;
    logic [31:0] age;
    logic        stale;
    assign age   = r_dec_now - r_dec_ts;
    assign stale = r_dec_on && (r_dec_ver != 8'd0) && (r_dec_now != 32'd0)
                   && (r_dec_ts != 32'd0) && (r_dec_now >= r_dec_ts) && (age > r_window);

    always_comb begin
        j_action = ACT_IGNORE;
        if (r_dec_ok) begin
            j_action = ACT_SET;
            if (r_dec_ver != 8'd0) begin
                if (r_dec_origin != 64'd0 && r_dec_origin == r_self_me)
                    j_action = ACT_IGNORE;
                else if (r_dec_seq < r_dec_last_seq)
                    j_action = ACT_IGNORE;
                else if (r_dec_seq == r_dec_last_seq && r_dec_on != r_dec_cur_on
                         && r_dec_origin >= r_self_me)
                    j_action = ACT_IGNORE;
            end
            if (j_action == ACT_SET && stale) j_action = ACT_STALE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (en) begin
            o_valid <= r_dec_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_action       <= 2'(j_action);
            o_msg_valid    <= r_dec_ok;
            o_lamp_on      <= r_dec_on;
            o_version      <= r_dec_ver;
            o_sequence_res <= r_dec_seq;
            o_timestamp    <= r_dec_ts;
            o_origin_id    <= r_dec_origin;
        end
    end

    // ---------------- assertions ----------------
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_msg_valid |-> o_action == 2'(ACT_IGNORE) && o_origin_id == 64'd0
                                    && !o_lamp_on)
        else $error("invalid message with non-zero result");

    a_stale_on_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_action == 2'(ACT_STALE) |-> o_lamp_on && o_version != 8'd0)
        else $error("stale suppression on a non-ON or legacy message");

    a_legacy_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_version == 8'd0 |-> o_sequence_res == 32'd0 && o_timestamp == 32'd0)
        else $error("legacy result carries record fields");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !r_dec_valid && !r_in_valid)
        else $error("pipe not empty after reset");

endmodule
`default_nettype wire

FILE: verif/lsmf_result_checker.sv
// ---------------------------------------------------------------------------
// lsmf_result_checker
// Watches the byte channel, the result channel and the register port of the
// lamp state message filter. Keeps its own copy of the message parse state
// and register values, works out the verdict due on each final byte, and
// compares every result item field by field against the oldest one waiting.
// ---------------------------------------------------------------------------
module lsmf_result_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // register port
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [3:0]  i_paddr,
    input  logic [63:0] i_pwdata,
    input  logic        i_pready,
    // byte channel
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last,
    input  logic [31:0] i_last_seq,
    input  logic        i_current_on,
    input  logic [31:0] i_now_epoch,
    // result channel
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [1:0]  i_action,
    input  logic        i_msg_valid,
    input  logic        i_lamp_on,
    input  logic [7:0]  i_version,
    input  logic [31:0] i_sequence_res,
    input  logic [31:0] i_timestamp,
    input  logic [63:0] i_origin_id,
    // status
    output int          o_errors,
    output int          o_pending,
    output int          o_results
);
    import lsmf_pkg::*;

    typedef struct packed {
        t_action     action;
        logic        valid;
        logic        on;
        logic [7:0]  ver;
        logic [31:0] seq;
        logic [31:0] ts;
        logic [63:0] origin;
    } t_verdict;

    t_verdict verdicts[$];

    // register copies
    logic [63:0] cfg_self;
    logic [31:0] cfg_window;

    // message parse state
    logic [6:0]  n_bytes;
    logic [2:0]  fld;
    logic        in_tok;
    logic        after_nul;
    logic        digits_done;
    t_match      whole_m;
    t_match      state_m;
    logic [7:0]  ver_acc;
    logic [63:0] org_acc;
    logic [3:0]  org_len;
    logic [31:0] seq_acc;
    logic [31:0] ts_acc;

    int fails = 0;
    int results = 0;

    assign o_errors  = fails;
    assign o_results = results;

    function automatic t_match onoff_next(input t_match m, input logic [7:0] c);
        if (m == M_START && c == CH_O) return M_O;
        if (m == M_O && c == CH_N) return M_ON;
        if (m == M_O && c == CH_F) return M_OF;
        if (m == M_OF && c == CH_F) return M_OFF;
        return M_FAIL;
    endfunction

    // acc*10 + digit, clamped to ceiling
    function automatic logic [31:0] sat_decimal(input logic [31:0] acc, input logic [7:0] c,
                                                input logic [31:0] ceiling);
        logic [35:0] wide;
        logic [7:0]  dig;
        dig  = c - CH_0;
        wide = {4'd0, acc} * 36'd10 + {28'd0, dig};
        return (wide > {4'd0, ceiling}) ? ceiling : wide[31:0];
    endfunction

    // own id stops at its first zero byte
    function automatic logic [63:0] trim_id(input logic [63:0] id);
        logic [63:0] r;
        logic        ended;
        r = '0;
        ended = 1'b0;
        for (int i = 7; i >= 0; i--) begin
            if (id[i*8 +: 8] == 8'd0) ended = 1'b1;
            if (!ended) r[i*8 +: 8] = id[i*8 +: 8];
        end
        return r;
    endfunction

    task automatic clear_message;
        n_bytes = '0;
        fld = '0;
        in_tok = 1'b0;
        after_nul = 1'b0;
        digits_done = 1'b0;
        whole_m = M_START;
        state_m = M_START;
        ver_acc = '0;
        org_acc = '0;
        org_len = '0;
        seq_acc = '0;
        ts_acc = '0;
    endtask

    task automatic take_char(input logic [7:0] c);
        logic [31:0] v;
        if (after_nul || c == CH_NUL) begin
            after_nul = 1'b1;
        end else begin
            whole_m = onoff_next(whole_m, c);
            if (c == CH_PIPE) begin
                in_tok = 1'b0;
            end else begin
                if (!in_tok) begin
                    in_tok = 1'b1;
                    if (fld < FLD_MAX) fld = fld + 3'd1;
                    digits_done = 1'b0;
                end
                if (fld == FLD_STATE) begin
                    state_m = onoff_next(state_m, c);
                end else if (fld == FLD_ORIGIN) begin
                    if (org_len < ORIGIN_BYTES_DEF) begin
                        org_acc[(7 - org_len) * 8 +: 8] = c;
                        org_len = org_len + 4'd1;
                    end
                end else if ((fld == FLD_VERSION || fld == FLD_SEQ || fld == FLD_TS)
                             && !digits_done) begin
                    if (c < CH_0 || c > CH_9) begin
                        digits_done = 1'b1;
                    end else if (fld == FLD_VERSION) begin
                        v = sat_decimal({24'd0, ver_acc}, c, 32'd255);
                        ver_acc = v[7:0];
                    end else if (fld == FLD_SEQ) begin
                        seq_acc = sat_decimal(seq_acc, c, '1);
                    end else begin
                        ts_acc = sat_decimal(ts_acc, c, '1);
                    end
                end
            end
        end
    endtask

    function automatic t_verdict close_message(input logic [31:0] ls, input logic con,
                                               input logic [31:0] now);
        t_verdict    v;
        logic [63:0] me;
        int          total;
        v = '0;
        v.action = ACT_IGNORE;
        total = int'(n_bytes) + 1;
        if (total < PAYLOAD_LIMIT_DEF) begin
            if (whole_m == M_ON || whole_m == M_OFF) begin
                v.valid = 1'b1;
                v.on = (whole_m == M_ON);
            end else if (fld >= FLD_TS && ver_acc == WIRE_VERSION_DEF &&
                         (state_m == M_ON || state_m == M_OFF)) begin
                v.valid = 1'b1;
                v.on = (state_m == M_ON);
                v.ver = ver_acc;
                v.origin = org_acc;
                v.seq = seq_acc;
                v.ts = ts_acc;
            end
        end
        if (v.valid) begin
            me = trim_id(cfg_self);
            v.action = ACT_SET;
            if (v.ver != 0) begin
                if (v.origin != 0 && v.origin == me) v.action = ACT_IGNORE;
                else if (v.seq < ls) v.action = ACT_IGNORE;
                else if (v.seq == ls && v.on != con && v.origin >= me) v.action = ACT_IGNORE;
            end
            // stale ON: only for timestamped records with the clock set
            if (v.action == ACT_SET && v.on && v.ver != 0 && now != 0 && v.ts != 0 &&
                now >= v.ts && (now - v.ts) > cfg_window)
                v.action = ACT_STALE;
        end
        return v;
    endfunction

    task automatic flag_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
        if (want !== got) begin
            fails++;
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_verdict want;
        if (!i_rst_n) begin
            verdicts.delete();
            cfg_self = '0;
            cfg_window = WINDOW_RESET;
            clear_message();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                results++;
                if (verdicts.size() == 0) begin
                    fails++;
                    $display("%0t: result item with none expected: expected nothing, actual %0h",
                             $time, i_action);
                end else begin
                    want = verdicts.pop_front();
                    flag_field("action", want.action, i_action);
                    flag_field("msg_valid", want.valid, i_msg_valid);
                    flag_field("lamp_on", want.on, i_lamp_on);
                    flag_field("version", want.ver, i_version);
                    flag_field("sequence_res", want.seq, i_sequence_res);
                    flag_field("timestamp", want.ts, i_timestamp);
                    flag_field("origin_id", want.origin, i_origin_id);
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr)
                    ADDR_SELF_ID: cfg_self = i_pwdata;
                    ADDR_WINDOW:  cfg_window = i_pwdata[31:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                take_char(i_data_byte);
                if (!i_last) begin
                    if (n_bytes < COUNT_MAX) n_bytes = n_bytes + 7'd1;
                end else begin
                    verdicts.push_back(close_message(i_last_seq, i_current_on, i_now_epoch));
                    clear_message();
                end
            end
        end
        o_pending <= verdicts.size();
    end

endmodule

FILE: verif/lamp_state_message_filter_top_tb.sv
// ---------------------------------------------------------------------------
// lamp_state_message_filter_top_tb
// Drives lamp state messages byte by byte into the filter: a directed set of
// legacy, record, echo, replay, tie, stale and overlong messages, then random
// well-formed records with random content mixed with broken records and
// noise, over several register settings. Both channels idle at random.
// Checking is done by lsmf_result_checker alongside the block.
// ---------------------------------------------------------------------------
module lamp_state_message_filter_top_tb;
    import lsmf_pkg::*;

    localparam int RANDOM_ITEMS = 1060;
    localparam int PHASE_ITEMS  = 250;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = '0;
    logic        last = 1'b0;
    logic [31:0] last_seq = '0;
    logic        current_on = 1'b0;
    logic [31:0] now_epoch = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  action;
    logic        msg_valid;
    logic        lamp_on;
    logic [7:0]  version;
    logic [31:0] sequence_res;
    logic [31:0] timestamp;
    logic [63:0] origin_id;

    int errors;
    int pending;
    int results;

    // stimulus bookkeeping
    logic [7:0]  msg_buf[$];
    logic [31:0] m_ls;
    logic [31:0] m_now;
    logic        m_con;
    logic [63:0] cur_self = '0;
    string       self_name = "";
    logic [31:0] cur_window = WINDOW_RESET;
    int          items = 0;
    int          msgs = 0;
    int          cfg_writes = 0;
    logic        idle_on = 1'b1;
    logic        stall_on = 1'b1;

    string origin_pool[8] = '{"lampA", "lampB", "kitchen1", "AB", "Z", "hall",
                              "zzzzzzzz", "hallway99"};

    always #4 clk = ~clk;

    lamp_state_message_filter_top u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_valid        (in_valid),
        .o_stall        (in_stall),
        .i_data_byte    (data_byte),
        .i_last         (last),
        .i_last_seq     (last_seq),
        .i_current_on   (current_on),
        .i_now_epoch    (now_epoch),
        .o_valid        (out_valid),
        .i_stall        (out_stall),
        .o_action       (action),
        .o_msg_valid    (msg_valid),
        .o_lamp_on      (lamp_on),
        .o_version      (version),
        .o_sequence_res (sequence_res),
        .o_timestamp    (timestamp),
        .o_origin_id    (origin_id)
    );

    lsmf_result_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .i_pready       (pready),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_data_byte    (data_byte),
        .i_last         (last),
        .i_last_seq     (last_seq),
        .i_current_on   (current_on),
        .i_now_epoch    (now_epoch),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_action       (action),
        .i_msg_valid    (msg_valid),
        .i_lamp_on      (lamp_on),
        .i_version      (version),
        .i_sequence_res (sequence_res),
        .i_timestamp    (timestamp),
        .i_origin_id    (origin_id),
        .o_errors       (errors),
        .o_pending      (pending),
        .o_results      (results)
    );

    always @(posedge clk)
        out_stall <= stall_on && ($urandom_range(99, 0) < 20);

    function automatic logic [63:0] pack_id(input string s);
        logic [63:0] v;
        v = '0;
        for (int k = 0; k < 8 && k < s.len(); k++)
            v[63 - 8*k -: 8] = s[k];
        return v;
    endfunction

    // any byte that is neither NUL nor a separator
    function automatic logic [7:0] text_char();
        logic [7:0] c;
        c = 8'($urandom_range(255, 1));
        if (c == CH_PIPE) c = 8'h7D;
        return c;
    endfunction

    task automatic add_text(input string s);
        for (int k = 0; k < s.len(); k++)
            msg_buf.push_back(s[k]);
    endtask

    task automatic add_state;
        if ($urandom_range(1, 0) != 0) add_text("ON");
        else                           add_text("OFF");
    endtask

    task automatic add_sep;
        int n;
        n = ($urandom_range(5, 0) == 0) ? $urandom_range(3, 2) : 1;
        repeat (n) msg_buf.push_back(CH_PIPE);
    endtask

    task automatic push_byte(input logic [7:0] b, input logic fin, input logic [31:0] ls,
                             input logic con, input logic [31:0] now);
        while (idle_on && $urandom_range(99, 0) < 20) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        data_byte  <= b;
        last       <= fin;
        last_seq   <= ls;
        current_on <= con;
        now_epoch  <= now;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        items++;
    endtask

    task automatic send_msg;
        if (msg_buf.size() == 0) msg_buf.push_back(text_char());
        for (int k = 0; k < msg_buf.size(); k++) begin
            if (k == msg_buf.size() - 1)
                push_byte(msg_buf[k], 1'b1, m_ls, m_con, m_now);
            else
                push_byte(msg_buf[k], 1'b0, $urandom, 1'($urandom_range(1, 0)), $urandom);
        end
        msgs++;
    endtask

    task automatic say(input string s, input logic [31:0] ls, input logic con,
                       input logic [31:0] now);
        msg_buf.delete();
        add_text(s);
        m_ls = ls;
        m_con = con;
        m_now = now;
        send_msg();
    endtask

    // wait for every outstanding verdict, then let the pipe drain
    task automatic settle;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [3:0] a, input logic [63:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= a;
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg_writes++;
    endtask

    task automatic set_config(input logic [63:0] self_v, input string name,
                              input logic [31:0] window);
        settle();
        write_reg(ADDR_SELF_ID, self_v);
        write_reg(ADDR_WINDOW, {32'd0, window});
        cur_self = self_v;
        self_name = name;
        cur_window = window;
    endtask

    task automatic pick_sideband;
        case ($urandom_range(3, 0))
            0: m_ls = 32'd0;
            1: m_ls = 32'hFFFF_FFFF;
            2: m_ls = $urandom_range(20, 0);
            default: m_ls = $urandom;
        endcase
        case ($urandom_range(7, 0))
            0: m_now = 32'd0;
            1: m_now = 32'hFFFF_FFFF;
            default: m_now = $urandom;
        endcase
        m_con = 1'($urandom_range(1, 0));
    endtask

    task automatic build_record;
        logic [31:0] v;
        int          n;
        msg_buf.delete();
        pick_sideband();
        if ($urandom_range(5, 0) == 0) add_text("|");
        case ($urandom_range(11, 0))
            0: add_text("01");
            1: add_text("0");
            2: add_text("2");
            3: add_text("300");
            4: add_text("1x");
            5: add_text("255");
            default: add_text("1");
        endcase
        add_sep();
        case ($urandom_range(9, 0))
            0: add_text("On");
            1: add_text("OFFF");
            2: add_text("O");
            default: add_state();
        endcase
        add_sep();
        case ($urandom_range(9, 0))
            0, 1: add_text(self_name != "" ? self_name : origin_pool[$urandom_range(7, 0)]);
            2: begin
                n = $urandom_range(12, 1);
                repeat (n) msg_buf.push_back(text_char());
            end
            3: begin
                // long origin can push the message past the payload limit
                n = $urandom_range(55, 30);
                repeat (n) msg_buf.push_back(text_char());
            end
            default: add_text(origin_pool[$urandom_range(7, 0)]);
        endcase
        add_sep();
        case ($urandom_range(9, 0))
            0, 1, 2: add_text($sformatf("%0d", m_ls));
            3: begin v = m_ls - 32'd1; add_text($sformatf("%0d", v)); end
            4: begin v = m_ls + 32'd1; add_text($sformatf("%0d", v)); end
            5: begin v = $urandom; add_text($sformatf("%0d", v)); end
            6: add_text("99999999999");
            7: add_text("x9");
            8: add_text("-3");
            default: begin v = m_ls + $urandom_range(50, 0); add_text($sformatf("%0d", v)); end
        endcase
        add_sep();
        case ($urandom_range(9, 0))
            0: begin v = m_now - cur_window - 32'd1; add_text($sformatf("%0d", v)); end
            1: begin v = m_now - cur_window; add_text($sformatf("%0d", v)); end
            2: begin v = m_now + 32'd3; add_text($sformatf("%0d", v)); end
            3: add_text("0");
            4: add_text("4294967296");
            5: begin v = $urandom; add_text($sformatf("%0d", v)); end
            6: ;
            default: begin
                v = m_now - $urandom_range(100, 0);
                add_text($sformatf("%0d", v));
            end
        endcase
        if ($urandom_range(3, 0) == 0) begin
            add_sep();
            add_text("x");
        end
        if ($urandom_range(7, 0) == 0) begin
            msg_buf.push_back(CH_NUL);
            n = $urandom_range(5, 0);
            repeat (n) msg_buf.push_back(8'($urandom_range(255, 0)));
        end
    endtask

    task automatic build_noise;
        int n;
        msg_buf.delete();
        pick_sideband();
        n = ($urandom_range(9, 0) == 0) ? $urandom_range(140, 64) : $urandom_range(40, 1);
        repeat (n) msg_buf.push_back(8'($urandom_range(255, 0)));
    endtask

    task automatic build_legacy;
        int n;
        msg_buf.delete();
        pick_sideband();
        add_state();
        if ($urandom_range(3, 0) == 0) begin
            msg_buf.push_back(CH_NUL);
            n = $urandom_range(4, 0);
            repeat (n) msg_buf.push_back(8'($urandom_range(255, 0)));
        end
    endtask

    task automatic new_phase(input int phase);
        logic [63:0] sv;
        string       nm;
        logic [31:0] w;
        int          p;
        // one long stretch with neither side idling
        idle_on  = (phase != 3);
        stall_on = (phase != 3);
        case ($urandom_range(5, 0))
            0: begin sv = '0; nm = ""; end
            1: begin sv = '1; nm = ""; end
            2: begin sv = 64'h4142_0043_4400_0000; nm = "AB"; end
            default: begin
                p = $urandom_range(7, 0);
                sv = pack_id(origin_pool[p]);
                nm = origin_pool[p];
            end
        endcase
        case ($urandom_range(5, 0))
            0: w = 32'd0;
            1: w = 32'hFFFF_FFFF;
            2: w = WINDOW_RESET;
            3: w = $urandom_range(100, 0);
            default: w = $urandom;
        endcase
        set_config(sv, nm, w);
    endtask

    initial begin
        int start_items;
        int next_phase;
        int phase;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: legacy forms, record forms and the judgement rules
        say("ON", 32'd0, 1'b0, 32'd0);
        say("OFF", 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
        say("OF", 32'd0, 1'b0, 32'd0);
        say("ONN", 32'd0, 1'b0, 32'd0);
        say("1|ON|lampA|5|100", 32'd5, 1'b1, 32'd200);
        say("1|OFF|lampA|4|0", 32'd5, 1'b1, 32'd200);
        say("||1|||ON||lampB|7|0|x|y", 32'd7, 1'b0, 32'd9);
        say("1|ON|kitchen1|9|1000", 32'd9, 1'b0, 32'd5000);
        say("1|ON|kitchen1|9|1000", 32'd9, 1'b0, 32'd0);
        say("1|ON|k|9|99999999999|", 32'd0, 1'b0, 32'hFFFF_FFFF);
        say("300|ON|a|1|1", 32'd0, 1'b0, 32'd5);
        say("01x|ON|a|4294967296|1", 32'd0, 1'b0, 32'd5);
        say("1|ON|a|-5|+7", 32'd0, 1'b1, 32'd100);
        // NUL ends the message text
        msg_buf.delete();
        add_text("ON");
        msg_buf.push_back(CH_NUL);
        add_text("FF");
        send_msg();
        // longest accepted length, then one byte over
        msg_buf.delete();
        add_text("1|ON|x|1|1");
        while (msg_buf.size() < PAYLOAD_LIMIT_DEF - 1) msg_buf.push_back(CH_PIPE);
        send_msg();
        msg_buf.push_back(CH_PIPE);
        send_msg();
        // byte count saturates
        msg_buf.delete();
        repeat (130) msg_buf.push_back(8'hFF);
        send_msg();
        say("|", 32'd0, 1'b0, 32'd0);
        msg_buf.delete();
        msg_buf.push_back(8'h80);
        send_msg();
        // own id with an inner zero byte, zero window
        set_config(64'h4142_0043_4400_0000, "AB", 32'd0);
        say("1|ON|AB|3|10", 32'd0, 1'b0, 32'd11);
        say("1|ON|ABC|3|10", 32'd0, 1'b0, 32'd11);
        // all-ones id and widest window
        set_config('1, "", 32'hFFFF_FFFF);
        say("1|OFF|lampA|8|1", 32'd8, 1'b1, 32'hFFFF_FFFF);
        say("1|ON|zz|0|1", 32'd0, 1'b0, 32'hFFFF_FFFF);

        // random traffic in phases of register settings
        start_items = items;
        phase = 0;
        next_phase = items;
        while (items - start_items < RANDOM_ITEMS) begin
            if (items >= next_phase) begin
                phase++;
                new_phase(phase);
                next_phase = items + PHASE_ITEMS;
            end
            case ($urandom_range(19, 0))
                0, 1: build_legacy();
                2, 3: build_noise();
                4, 5: begin
                    build_record();
                    while (msg_buf.size() > 1 && $urandom_range(3, 0) != 0)
                        void'(msg_buf.pop_back());
                end
                default: build_record();
            endcase
            send_msg();
        end

        settle();
        $display("Run covered %0d bytes in %0d messages and %0d checked verdicts,",
                 items, msgs, results);
        $display("over %0d register writes with legacy, record, noise and overlong traffic.",
                 cfg_writes);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
